### rtl/mhsic_pkg.sv
package mhsic_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned IN_W            = 16;
  localparam int unsigned OFFSET_W        = 17;
  localparam int unsigned COUNT_W         = 16;
  localparam int unsigned FRAC_BITS       = 16;
  localparam int unsigned RATIO_W         = 24;

  localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RST = COUNT_W'(500);
  localparam logic [RATIO_W-1:0] RATIO_MAX        = '1;

  typedef enum logic [1:0] {
    SCALE_EXACT  = 2'd0,
    SCALE_SAT    = 2'd1,
    SCALE_ZERO_Y = 2'd2
  } scale_status_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_e;

  // request from the control side to the ratio unit
  typedef struct packed {
    logic start;
    logic take;
  } div_req_t;

  // status back from the ratio unit
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### rtl/mhsic_axis_lane.sv
module mhsic_axis_lane
  import mhsic_pkg::*;
#(
  parameter int unsigned SampleBits = SAMPLE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         update_i,
  input  logic                         last_i,
  input  logic signed [SampleBits-1:0] sample_i,
  output logic signed [SampleBits-1:0] high_o,
  output logic signed [SampleBits-1:0] low_o
);

  localparam logic signed [SampleBits-1:0] Bottom = {1'b1, {(SampleBits-1){1'b0}}};
  localparam logic signed [SampleBits-1:0] Top    = ~Bottom;

  logic signed [SampleBits-1:0] high_q, high_d, low_q, low_d;
  logic signed [SampleBits-1:0] high_n, low_n;

  // extremes including the current sample
  always_comb begin
    high_n = (sample_i > high_q) ? sample_i : high_q;
    low_n  = (sample_i < low_q) ? sample_i : low_q;
    high_d = high_q;
    low_d  = low_q;
    if (update_i) begin
      high_d = last_i ? Bottom : high_n;
      low_d  = last_i ? Top : low_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_q <= Bottom;
      low_q  <= Top;
    end else begin
      high_q <= high_d;
      low_q  <= low_d;
    end
  end

  assign high_o = high_n;
  assign low_o  = low_n;

endmodule

### rtl/mhsic_ratio_div.sv
module mhsic_ratio_div
  import mhsic_pkg::*;
#(
  parameter int unsigned SampleBits = SAMPLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  div_req_t              req_i,
  input  logic [SampleBits-1:0] rx_i,
  input  logic [SampleBits-1:0] ry_i,
  output div_stat_t             stat_o,
  output logic [RATIO_W-1:0]    ratio_o,
  output scale_status_e         status_o
);

  localparam int unsigned DivW = SampleBits + FRAC_BITS;
  localparam int unsigned CntW = $clog2(DivW);
  localparam logic [DivW-1:0] SatLimit = DivW'(RATIO_MAX);

  div_state_e state_q, state_d;

  logic [SampleBits:0]   rem_q, rem_d;
  logic [DivW-1:0]       quo_q, quo_d;
  logic [SampleBits-1:0] den_q, den_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  zero_q, zero_d;
  logic [SampleBits:0]   shifted;
  logic                  fits;

  // one restoring step per cycle
  always_comb begin
    shifted = {rem_q[SampleBits-1:0], quo_q[DivW-1]};
    fits    = shifted >= {1'b0, den_q};
  end

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    zero_d  = zero_q;
    unique case (state_q)
      DIV_IDLE: begin
        if (req_i.start) begin
          rem_d  = '0;
          quo_d  = {rx_i, {FRAC_BITS{1'b0}}};
          den_d  = ry_i;
          cnt_d  = CntW'(DivW - 1);
          zero_d = (ry_i == '0);
          state_d = (ry_i == '0) ? DIV_DONE : DIV_RUN;
        end
      end
      DIV_RUN: begin
        rem_d = fits ? (shifted - {1'b0, den_q}) : shifted;
        quo_d = {quo_q[DivW-2:0], fits};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = DIV_DONE;
        end
      end
      DIV_DONE: begin
        if (req_i.take) begin
          state_d = DIV_IDLE;
        end
      end
      default: state_d = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    den_q  <= den_d;
    zero_q <= zero_d;
  end

  always_comb begin
    if (zero_q) begin
      ratio_o  = RATIO_MAX;
      status_o = SCALE_ZERO_Y;
    end else if (quo_q > SatLimit) begin
      ratio_o  = RATIO_MAX;
      status_o = SCALE_SAT;
    end else begin
      ratio_o  = quo_q[RATIO_W-1:0];
      status_o = SCALE_EXACT;
    end
  end

  assign stat_o.busy = (state_q != DIV_IDLE);
  assign stat_o.done = (state_q == DIV_DONE);

endmodule

### rtl/mag_hard_soft_iron_calibrator_core.sv
// result path: a run-ending beat starts the ratio divider, which skips its steps on a zero y range
// throughput: one sample beat per cycle inside a run; at each run end the input
//   stalls for the SAMPLE_BITS+16 step iterative ratio divider and until its result
//   moves into the output register
// reset: rst_ni async active low; sample_count returns to 500, extremes to their
//   empty values, counter to zero, output register empty
module mag_hard_soft_iron_calibrator_core
  import mhsic_pkg::*;
#(
  parameter int unsigned SampleBits = SAMPLE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       cfg_we_i,
  input  logic [COUNT_W-1:0]         cfg_wdata_i,
  // sample channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [IN_W-1:0]     mag_x_i,
  input  logic signed [IN_W-1:0]     mag_y_i,
  input  logic signed [IN_W-1:0]     mag_z_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [OFFSET_W-1:0] offset_x_twice_o,
  output logic signed [OFFSET_W-1:0] offset_y_twice_o,
  output logic signed [OFFSET_W-1:0] offset_z_twice_o,
  output logic [RATIO_W-1:0]         scale_ratio_o,
  output logic [1:0]                 scale_status_o
);

  // sample count register
  logic [COUNT_W-1:0] sample_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= SAMPLE_COUNT_RST;
    end else if (cfg_we_i) begin
      sample_count_q <= cfg_wdata_i;
    end
  end

  // handshake and run counter
  div_req_t  div_req;
  div_stat_t div_stat;
  logic      accept;
  logic      last;

  logic [COUNT_W-1:0] seen_q, seen_d, seen_inc, need;

  assign in_ready_o = !div_stat.busy;
  assign accept     = in_valid_i && in_ready_o;

  // a count of zero acts as one; a wrap of the counter also ends the run
  always_comb begin
    seen_inc = seen_q + 1'b1;
    need     = (sample_count_q == '0) ? COUNT_W'(1) : sample_count_q;
    last     = (seen_inc == '0) || (seen_inc >= need);
    seen_d   = seen_q;
    if (accept) begin
      seen_d = last ? '0 : seen_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else begin
      seen_q <= seen_d;
    end
  end

  // one min/max lane per axis, only the low SampleBits of each field count
  logic signed [SampleBits-1:0] xs, ys, zs;
  logic signed [SampleBits-1:0] x_high, x_low, y_high, y_low, z_high, z_low;

  assign xs = mag_x_i[SampleBits-1:0];
  assign ys = mag_y_i[SampleBits-1:0];
  assign zs = mag_z_i[SampleBits-1:0];

  mhsic_axis_lane #(.SampleBits(SampleBits)) u_lane_x (
    .clk_i, .rst_ni, .update_i(accept), .last_i(last),
    .sample_i(xs), .high_o(x_high), .low_o(x_low)
  );

  mhsic_axis_lane #(.SampleBits(SampleBits)) u_lane_y (
    .clk_i, .rst_ni, .update_i(accept), .last_i(last),
    .sample_i(ys), .high_o(y_high), .low_o(y_low)
  );

  mhsic_axis_lane #(.SampleBits(SampleBits)) u_lane_z (
    .clk_i, .rst_ni, .update_i(accept), .last_i(last),
    .sample_i(zs), .high_o(z_high), .low_o(z_low)
  );

  // merge: offsets and ranges from the lane extremes, current beat included
  logic signed [SampleBits:0] x_sum, y_sum, z_sum, x_diff, y_diff;
  logic [SampleBits-1:0]      rx, ry;

  always_comb begin
    x_sum  = {x_high[SampleBits-1], x_high} + {x_low[SampleBits-1], x_low};
    y_sum  = {y_high[SampleBits-1], y_high} + {y_low[SampleBits-1], y_low};
    z_sum  = {z_high[SampleBits-1], z_high} + {z_low[SampleBits-1], z_low};
    // high is never below low once a sample is in, so the range fits SampleBits
    x_diff = {x_high[SampleBits-1], x_high} - {x_low[SampleBits-1], x_low};
    y_diff = {y_high[SampleBits-1], y_high} - {y_low[SampleBits-1], y_low};
    rx     = x_diff[SampleBits-1:0];
    ry     = y_diff[SampleBits-1:0];
  end

  // offsets held while the ratio is worked out
  logic signed [OFFSET_W-1:0] off_x_q, off_y_q, off_z_q;

  always_ff @(posedge clk_i) begin
    if (accept && last) begin
      off_x_q <= OFFSET_W'(x_sum);
      off_y_q <= OFFSET_W'(y_sum);
      off_z_q <= OFFSET_W'(z_sum);
    end
  end

  logic [RATIO_W-1:0] ratio;
  scale_status_e      status;

  assign div_req.start = accept && last;
  assign div_req.take  = div_stat.done && (!out_valid_o || out_ready_i);

  mhsic_ratio_div #(.SampleBits(SampleBits)) u_ratio_div (
    .clk_i,
    .rst_ni,
    .req_i   (div_req),
    .rx_i    (rx),
    .ry_i    (ry),
    .stat_o  (div_stat),
    .ratio_o (ratio),
    .status_o(status)
  );

  // output register, lets the next run start while a result waits
  logic                       out_valid_q;
  logic signed [OFFSET_W-1:0] out_x_q, out_y_q, out_z_q;
  logic [RATIO_W-1:0]         out_ratio_q;
  scale_status_e              out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (div_req.take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_req.take) begin
      out_x_q      <= off_x_q;
      out_y_q      <= off_y_q;
      out_z_q      <= off_z_q;
      out_ratio_q  <= ratio;
      out_status_q <= status;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign offset_x_twice_o = out_x_q;
  assign offset_y_twice_o = out_y_q;
  assign offset_z_twice_o = out_z_q;
  assign scale_ratio_o    = out_ratio_q;
  assign scale_status_o   = out_status_q;

  // a run-ending beat always hands work to the divider
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last |=> div_stat.busy)
    else $error("run end did not start the ratio divider");

  // the run counter stays clear while the divider owns a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(div_stat.busy) |-> seen_q == '0)
    else $error("sample counter not cleared at run end");

  // a zero y range or saturation always reports full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_status_q == SCALE_ZERO_Y || out_status_q == SCALE_SAT)
      |-> scale_ratio_o == RATIO_MAX)
    else $error("flagged ratio is not saturated");

  // no result moves out of the divider unless it finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(div_stat.done))
    else $error("result loaded without a finished ratio");

endmodule

### tb/mhsic_result_check.sv
module mhsic_result_check
  import mhsic_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [COUNT_W-1:0]         cfg_wdata_i,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic signed [IN_W-1:0]     mag_x_i,
  input  logic signed [IN_W-1:0]     mag_y_i,
  input  logic signed [IN_W-1:0]     mag_z_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic signed [OFFSET_W-1:0] offset_x_twice_i,
  input  logic signed [OFFSET_W-1:0] offset_y_twice_i,
  input  logic signed [OFFSET_W-1:0] offset_z_twice_i,
  input  logic [RATIO_W-1:0]         scale_ratio_i,
  input  logic [1:0]                 scale_status_i,
  output int unsigned                mismatches_o,
  output int unsigned                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [OFFSET_W-1:0] off_x;
    logic signed [OFFSET_W-1:0] off_y;
    logic signed [OFFSET_W-1:0] off_z;
    logic [RATIO_W-1:0]         ratio;
    scale_status_e              status;
  } calib_result_t;

  logic [COUNT_W-1:0]     run_length;
  logic [COUNT_W-1:0]     seen;
  logic signed [IN_W-1:0] hi_x, lo_x, hi_y, lo_y, hi_z, lo_z;
  calib_result_t          calib_expected_q[$];
  int unsigned            mismatches;

  function automatic void clear_run();
    hi_x = {1'b1, {(IN_W-1){1'b0}}};
    hi_y = hi_x;
    hi_z = hi_x;
    lo_x = {1'b0, {(IN_W-1){1'b1}}};
    lo_y = lo_x;
    lo_z = lo_x;
    seen = '0;
  endfunction

  // offsets and x/y span ratio of the run gathered so far
  function automatic calib_result_t close_run();
    calib_result_t     r;
    longint unsigned   span_x;
    longint unsigned   span_y;
    longint unsigned   quotient;
    span_x  = longint'(hi_x) - longint'(lo_x);
    span_y  = longint'(hi_y) - longint'(lo_y);
    r.off_x = hi_x + lo_x;
    r.off_y = hi_y + lo_y;
    r.off_z = hi_z + lo_z;
    if (span_y == 0) begin
      r.ratio  = RATIO_MAX;
      r.status = SCALE_ZERO_Y;
    end else begin
      quotient = (span_x << FRAC_BITS) / span_y;
      if (quotient > RATIO_MAX) begin
        r.ratio  = RATIO_MAX;
        r.status = SCALE_SAT;
      end else begin
        r.ratio  = RATIO_W'(quotient);
        r.status = SCALE_EXACT;
      end
    end
    return r;
  endfunction

  task automatic check_field(input string field, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    calib_result_t    want;
    logic [COUNT_W:0] need;
    if (!rst_ni) begin
      run_length = SAMPLE_COUNT_RST;
      clear_run();
      calib_expected_q.delete();
      mismatches = 0;
      mismatches_o <= 0;
      pending_o <= 0;
    end else begin
      // result beat against the oldest expectation
      if (out_valid_i && out_ready_i) begin
        if (calib_expected_q.size() == 0) begin
          $display("%0t: unexpected result, actual %0d %0d %0d %0d %0d", $time,
                   offset_x_twice_i, offset_y_twice_i, offset_z_twice_i,
                   scale_ratio_i, scale_status_i);
          mismatches++;
        end else begin
          want = calib_expected_q.pop_front();
          check_field("offset_x_twice", want.off_x, offset_x_twice_i);
          check_field("offset_y_twice", want.off_y, offset_y_twice_i);
          check_field("offset_z_twice", want.off_z, offset_z_twice_i);
          check_field("scale_ratio", want.ratio, scale_ratio_i);
          check_field("scale_status", want.status, scale_status_i);
        end
      end
      if (cfg_we_i) begin
        run_length = cfg_wdata_i;
      end
      // sample beat: track extremes, close the run once enough samples are in
      if (in_valid_i && in_ready_i) begin
        if (mag_x_i > hi_x) hi_x = mag_x_i;
        if (mag_x_i < lo_x) lo_x = mag_x_i;
        if (mag_y_i > hi_y) hi_y = mag_y_i;
        if (mag_y_i < lo_y) lo_y = mag_y_i;
        if (mag_z_i > hi_z) hi_z = mag_z_i;
        if (mag_z_i < lo_z) lo_z = mag_z_i;
        seen++;
        need = (run_length == '0) ? (COUNT_W+1)'(1) : {1'b0, run_length};
        if (seen == 0 || seen >= need) begin
          calib_expected_q.push_back(close_run());
          clear_run();
        end
      end
      mismatches_o <= mismatches;
      pending_o <= calib_expected_q.size();
    end
  end

endmodule

### tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mhsic_pkg::*;

  localparam int unsigned ITEMS_TOTAL     = 950;
  // covers the result latency of a run-ending beat, with some margin on top
  localparam int unsigned SETTLE_CYCLES   = 40;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned IDLE_PCT        = 28;

  // how a random phase shapes its samples
  typedef enum int unsigned {
    FLAVOR_WIDE,
    FLAVOR_FLAT_Y,
    FLAVOR_CORNERS
  } flavor_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                cfg_we = 1'b0;
  logic [COUNT_W-1:0]  cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [IN_W-1:0]     mag_x = '0;
  logic [IN_W-1:0]     mag_y = '0;
  logic [IN_W-1:0]     mag_z = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [OFFSET_W-1:0] offset_x_twice;
  logic [OFFSET_W-1:0] offset_y_twice;
  logic [OFFSET_W-1:0] offset_z_twice;
  logic [RATIO_W-1:0]  scale_ratio;
  logic [1:0]          scale_status;

  // shared knobs between the sample side and the result side
  logic steady = 1'b0;
  logic hold_off_req = 1'b0;

  int unsigned mismatches;
  int unsigned pending;

  mag_hard_soft_iron_calibrator_core dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .mag_x_i          (mag_x),
    .mag_y_i          (mag_y),
    .mag_z_i          (mag_z),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .offset_x_twice_o (offset_x_twice),
    .offset_y_twice_o (offset_y_twice),
    .offset_z_twice_o (offset_z_twice),
    .scale_ratio_o    (scale_ratio),
    .scale_status_o   (scale_status)
  );

  mhsic_result_check u_result_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .mag_x_i          (mag_x),
    .mag_y_i          (mag_y),
    .mag_z_i          (mag_z),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .offset_x_twice_i (offset_x_twice),
    .offset_y_twice_i (offset_y_twice),
    .offset_z_twice_i (offset_z_twice),
    .scale_ratio_i    (scale_ratio),
    .scale_status_i   (scale_status),
    .mismatches_o     (mismatches),
    .pending_o        (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // offer one sample beat; valid stays up across back-to-back beats and only
  // drops when a random gap is taken
  task automatic offer_sample(input logic [IN_W-1:0] x, input logic [IN_W-1:0] y,
                              input logic [IN_W-1:0] z);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_valid <= 1'b1;
    mag_x    <= x;
    mag_y    <= y;
    mag_z    <= z;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid, let every expected result arrive, then let a run in flight
  // with no result settle before the block is touched again
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_run_length(input logic [COUNT_W-1:0] len);
    wait_for_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [IN_W-1:0] corner_or_random();
    case ($urandom_range(0, 7))
      0:       return {1'b1, {(IN_W-1){1'b0}}};
      1:       return {1'b0, {(IN_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return IN_W'($urandom);
    endcase
  endfunction

  // result side: random back-pressure, one long hold-off on request
  initial begin
    logic hold_taken;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // watchdog: ends the run when no beat moves for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: watchdog, no beat for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    int unsigned        sent;
    int unsigned        phase;
    int unsigned        phase_len;
    int unsigned        pick;
    logic [COUNT_W-1:0] len;
    logic [IN_W-1:0]    flat_base;
    logic [IN_W-1:0]    sx, sy, sz;
    flavor_e            flavor;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset length of 500: a few samples, then a shorter length cuts the run
    offer_sample(16'h0010, 16'hfff0, 16'h0100);
    offer_sample(16'hff00, 16'h0020, 16'h0000);
    offer_sample(16'h0005, 16'h0000, 16'hfe00);
    set_run_length(16'd2);
    offer_sample(16'h0000, 16'h0000, 16'h0000);

    // single-sample runs: y range always zero, offsets at both ends
    set_run_length(16'd1);
    offer_sample(16'h7fff, 16'h7fff, 16'h7fff);
    offer_sample(16'h8000, 16'h8000, 16'h8000);

    // zero length acts like one
    set_run_length(16'd0);
    offer_sample(16'h0000, 16'h0000, 16'h0000);
    offer_sample(16'hffff, 16'h0001, 16'h8001);

    // two-sample runs around the ratio limits
    set_run_length(16'd2);
    offer_sample(16'h8000, 16'h0000, 16'h1234);  // full x span over unit y span
    offer_sample(16'h7fff, 16'h0001, 16'hedcb);
    offer_sample(16'h0000, 16'h0000, 16'h0000);  // one step past the largest ratio
    offer_sample(16'h0100, 16'h0001, 16'h0000);
    offer_sample(16'h0000, 16'h0000, 16'h0000);  // largest exact ratio, y span 1
    offer_sample(16'h00ff, 16'h0001, 16'h0000);
    offer_sample(16'hff9c, 16'hfed4, 16'h4000);  // plain exact ratio
    offer_sample(16'h0064, 16'h012c, 16'hc000);
    offer_sample(16'h0000, 16'h8000, 16'h7fff);  // zero x span
    offer_sample(16'h0000, 16'h7fff, 16'h8000);

    // longest run length, then lowered below the samples already seen
    set_run_length(16'hffff);
    offer_sample(16'h0123, 16'h0456, 16'h0789);
    offer_sample(16'hfedc, 16'hfba9, 16'hf876);
    offer_sample(16'h7000, 16'h9000, 16'h0001);
    offer_sample(16'h8fff, 16'h6fff, 16'hffff);
    set_run_length(16'd3);
    offer_sample(16'h0000, 16'h0000, 16'h0000);

    // random phases, mostly short runs so results keep coming
    sent  = 0;
    phase = 0;
    while (sent < ITEMS_TOTAL) begin
      phase++;
      pick = $urandom_range(0, 9);
      if (phase == 1 || (pick >= 1 && pick <= 3)) len = 16'd1;
      else if (pick == 0) len = 16'd0;
      else if (pick <= 6) len = COUNT_W'($urandom_range(2, 6));
      else if (pick <= 8) len = COUNT_W'($urandom_range(7, 30));
      else len = COUNT_W'($urandom_range(31, 120));
      set_run_length(len);
      // first phase: result side stalls for a long time, block fills up
      if (phase == 1) hold_off_req <= 1'b1;
      // second phase: no idling on either side
      steady    <= (phase == 2);
      flavor    = flavor_e'($urandom_range(0, 2));
      flat_base = IN_W'($urandom);
      phase_len = $urandom_range(40, 120);
      repeat (phase_len) begin
        sx = IN_W'($urandom);
        sy = IN_W'($urandom);
        sz = IN_W'($urandom);
        case (flavor)
          FLAVOR_FLAT_Y: sy = flat_base + IN_W'($urandom_range(0, 2));
          FLAVOR_CORNERS: begin
            sx = corner_or_random();
            sy = corner_or_random();
            sz = corner_or_random();
          end
          default: ;
        endcase
        offer_sample(sx, sy, sz);
        sent++;
      end
    end

    steady <= 1'b0;
    wait_for_results();
    if (pending != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending);
    end
    if (mismatches == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
